/* hw/rtl/etm_pkg.sv */
// shared types and field widths for the edge twin matcher
package etm_pkg;

    localparam int VERT_W = 20;
    localparam int NUM_W  = 10;
    localparam int STAT_W = 2;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NOT_BUILT = 2'd1,
        STAT_RANGE    = 2'd2,
        STAT_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD,
        ST_RD_OUT,
        ST_K_A,
        ST_K_B,
        ST_K_C,
        ST_S_X0,
        ST_S_X1,
        ST_S_X2,
        ST_S_J0,
        ST_S_J1,
        ST_S_J2,
        ST_L0,
        ST_L1,
        ST_L2,
        ST_L3
    } state_t;

    typedef struct packed {
        logic gt;
        logic eq;
    } cmp_res_t;

endpackage

/* hw/rtl/etm_key_cmp.sv */
// shared key comparator used by the key, sort and link passes
module etm_key_cmp #(
    parameter int KEY_W = 40
) (
    input  logic [KEY_W-1:0] key_a,
    input  logic [KEY_W-1:0] key_b,
    output etm_pkg::cmp_res_t res
);
    import etm_pkg::*;

    always_comb begin
        res.gt = key_a > key_b;
        res.eq = key_a == key_b;
    end

endmodule

/* hw/rtl/edge_twin_matcher.sv */
// edge twin matcher: corner load, sort-based twin build and edge read-back
// load beat gives no result; read beat result comes out of ST_RD_OUT, reached via ST_RD when ok
// build on last corner of mesh: keys via ST_K_A..C per edge, sort via ST_S_X0..2 per edge
// and ST_S_J0..2 per shifted position, links via ST_L0..2 per pair, ST_L3 if twinned; not ready
// all key comparisons go through one key comparator; a stalled result holds off the next beat
// aresetn clears counts, build flags and handshake state; memories are not cleared
module edge_twin_matcher #(
    parameter int MAX_EDGES   = 1024,
    parameter int VERTEX_BITS = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // corner_vertex[19:0], last_in_face[20], edge_number[30:21]
    input  logic        s_tuser,   // kind
    input  logic        s_tlast,   // last_in_mesh
    output logic        m_tvalid,
    input  logic        m_tready,
    // low_vertex[19:0], high_vertex[39:20], own_face[49:40], neighbour_face[59:50],
    // twin_edge[69:60], paired[70]
    output logic [71:0] m_tdata,
    output logic [1:0]  m_tuser    // status
);
    import etm_pkg::*;

    // widths of stored items
    localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW  = EW + 1;
    localparam int VW  = (VERTEX_BITS < VERT_W) ? VERTEX_BITS : VERT_W;
    localparam int KW  = 2 * VW;
    localparam int TW  = 1 + EW + NUM_W;

    // memories
    logic [VW-1:0]    corner_mem [MAX_EDGES];
    logic [NUM_W-1:0] face_mem   [MAX_EDGES];
    logic [KW-1:0]    key_mem    [MAX_EDGES];
    logic [EW-1:0]    sort_mem   [MAX_EDGES];
    logic [TW-1:0]    twin_mem   [MAX_EDGES];

    // input fields
    logic [VERT_W-1:0] in_vert;
    logic              in_lface;
    logic [NUM_W-1:0]  in_num;
    assign in_vert  = s_tdata[19:0];
    assign in_lface = s_tdata[20];
    assign in_num   = s_tdata[30:21];

    // control state
    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [NUM_W-1:0] face_cnt_reg, face_cnt_next;
    logic            built_reg, built_next;
    logic            ovf_reg, ovf_next;
    logic [CW-1:0]   i_reg, i_next;      // edge / outer loop index
    logic [CW-1:0]   j_reg, j_next;      // insertion position
    logic [CW-1:0]   start_reg, start_next;
    logic            out_valid_reg, out_valid_next;

    // payload state
    logic [EW-1:0]    x_reg, x_next;
    logic [EW-1:0]    y_reg, y_next;
    logic [KW-1:0]    kx_reg, kx_next;
    logic [VW-1:0]    a_reg, a_next;
    logic [EW-1:0]    p_reg, p_next;
    logic [EW-1:0]    q_reg, q_next;
    logic [NUM_W-1:0] fp_reg, fp_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [1:0]       stat_reg, stat_next;
    logic [71:0]      out_data_reg, out_data_next;
    logic [1:0]       out_stat_reg, out_stat_next;

    // memory ports
    logic             cw_en;
    logic [EW-1:0]    cw_addr, cr_addr;
    logic [VW-1:0]    cw_data, cr_q;
    logic             fw_en;
    logic [EW-1:0]    fw_addr, fa_addr, fb_addr;
    logic [NUM_W-1:0] fw_data, fa_q, fb_q;
    logic             kw_en;
    logic [EW-1:0]    kw_addr, ka_addr, kb_addr;
    logic [KW-1:0]    kw_data, ka_q, kb_q;
    logic             sw_en;
    logic [EW-1:0]    sw_addr, sa_addr, sb_addr;
    logic [EW-1:0]    sw_data, sa_q, sb_q;
    logic             tw_en;
    logic [EW-1:0]    tw_addr, tr_addr;
    logic [TW-1:0]    tw_data, tr_q;

    always_ff @(posedge aclk) begin
        if (cw_en) corner_mem[cw_addr] <= cw_data;
        cr_q <= corner_mem[cr_addr];
    end

    always_ff @(posedge aclk) begin
        if (fw_en) face_mem[fw_addr] <= fw_data;
        fa_q <= face_mem[fa_addr];
        fb_q <= face_mem[fb_addr];
    end

    always_ff @(posedge aclk) begin
        if (kw_en) key_mem[kw_addr] <= kw_data;
        ka_q <= key_mem[ka_addr];
        kb_q <= key_mem[kb_addr];
    end

    always_ff @(posedge aclk) begin
        if (sw_en) sort_mem[sw_addr] <= sw_data;
        sa_q <= sort_mem[sa_addr];
        sb_q <= sort_mem[sb_addr];
    end

    always_ff @(posedge aclk) begin
        if (tw_en) twin_mem[tw_addr] <= tw_data;
        tr_q <= twin_mem[tr_addr];
    end

    // the one comparator: the two corners while building keys, the held key during
    // the sort, the two key ports while linking
    logic [KW-1:0] cmp_a;
    logic [KW-1:0] cmp_b;
    cmp_res_t      cmp;
    assign cmp_a = (state_reg == ST_K_C) ? KW'(a_reg) : ka_q;
    assign cmp_b = (state_reg == ST_S_J2) ? kx_reg :
                   (state_reg == ST_K_C)  ? KW'(cr_q) : kb_q;

    etm_key_cmp #(.KEY_W(KW)) u_cmp (
        .key_a (cmp_a),
        .key_b (cmp_b),
        .res   (cmp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            face_cnt_reg  <= '0;
            built_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            start_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            face_cnt_reg  <= face_cnt_next;
            built_reg     <= built_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            start_reg     <= start_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        kx_reg       <= kx_next;
        a_reg        <= a_next;
        p_reg        <= p_next;
        q_reg        <= q_next;
        fp_reg       <= fp_next;
        num_reg      <= num_next;
        stat_reg     <= stat_next;
        out_data_reg <= out_data_next;
        out_stat_reg <= out_stat_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_stat_reg;

    always_comb begin
        logic [CW-1:0]    cnt_base;
        logic [NUM_W-1:0] face_base;
        logic             same_face;
        logic [CW-1:0]    e_inc;
        logic [VW-1:0]    b_v;
        logic             out_free;

        state_next     = state_reg;
        count_next     = count_reg;
        face_cnt_next  = face_cnt_reg;
        built_next     = built_reg;
        ovf_next       = ovf_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        start_next     = start_reg;
        out_valid_next = out_valid_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        kx_next        = kx_reg;
        a_next         = a_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        fp_next        = fp_reg;
        num_next       = num_reg;
        stat_next      = stat_reg;
        out_data_next  = out_data_reg;
        out_stat_next  = out_stat_reg;

        cw_en = 1'b0; cw_addr = '0; cw_data = '0; cr_addr = '0;
        fw_en = 1'b0; fw_addr = '0; fw_data = '0; fa_addr = '0; fb_addr = '0;
        kw_en = 1'b0; kw_addr = '0; kw_data = '0; ka_addr = '0; kb_addr = '0;
        sw_en = 1'b0; sw_addr = '0; sw_data = '0; sa_addr = '0; sb_addr = '0;
        tw_en = 1'b0; tw_addr = '0; tw_data = '0; tr_addr = '0;

        cnt_base  = count_reg;
        face_base = face_cnt_reg;
        same_face = 1'b0;
        e_inc     = i_reg + 1'b1;
        b_v       = cr_q;
        out_free  = !out_valid_reg || m_tready;

        if (m_tready) out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (!s_tuser) begin
                        // load beat; a finished mesh is dropped first
                        if (built_reg) begin
                            cnt_base  = '0;
                            face_base = '0;
                            ovf_next  = 1'b0;
                            built_next = 1'b0;
                        end
                        count_next    = cnt_base;
                        face_cnt_next = face_base;
                        if (cnt_base < CW'(MAX_EDGES)) begin
                            cw_en      = 1'b1;
                            cw_addr    = cnt_base[EW-1:0];
                            cw_data    = in_vert[VW-1:0];
                            fw_en      = 1'b1;
                            fw_addr    = cnt_base[EW-1:0];
                            fw_data    = face_base;
                            count_next = cnt_base + 1'b1;
                        end else begin
                            ovf_next = 1'b1;
                        end
                        if (in_lface || s_tlast) face_cnt_next = face_base + 1'b1;
                        if (s_tlast) begin
                            // count is at least one here, so the key pass starts
                            i_next     = '0;
                            start_next = '0;
                            state_next = ST_K_A;
                        end
                    end else begin
                        // read beat: status decided now, memories read if ok
                        num_next = in_num;
                        if (!built_reg) begin
                            stat_next  = STAT_NOT_BUILT;
                            state_next = ST_RD_OUT;
                        end else if (ovf_reg) begin
                            stat_next  = STAT_OVERFLOW;
                            state_next = ST_RD_OUT;
                        end else if (32'(in_num) >= 32'(count_reg)) begin
                            stat_next  = STAT_RANGE;
                            state_next = ST_RD_OUT;
                        end else begin
                            stat_next  = STAT_OK;
                            state_next = ST_RD;
                        end
                    end
                end
            end

            ST_RD: begin
                ka_addr    = EW'(num_reg);
                fa_addr    = EW'(num_reg);
                tr_addr    = EW'(num_reg);
                state_next = ST_RD_OUT;
            end

            ST_RD_OUT: begin
                // keep the read addresses so the data holds while the result waits
                ka_addr = EW'(num_reg);
                fa_addr = EW'(num_reg);
                tr_addr = EW'(num_reg);
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_stat_next  = stat_reg;
                    out_data_next  = '0;
                    if (stat_reg == STAT_OK) begin
                        out_data_next[19:0]  = VERT_W'(ka_q[KW-1:VW]);
                        out_data_next[39:20] = VERT_W'(ka_q[VW-1:0]);
                        out_data_next[49:40] = fa_q;
                        out_data_next[59:50] = tr_q[NUM_W-1:0];
                        out_data_next[69:60] = NUM_W'(tr_q[NUM_W+EW-1:NUM_W]);
                        out_data_next[70]    = tr_q[TW-1];
                    end
                    state_next = ST_IDLE;
                end
            end

            // key pass: edge i joins corner i with the next corner of its face
            ST_K_A: begin
                cr_addr    = i_reg[EW-1:0];
                fa_addr    = i_reg[EW-1:0];
                fb_addr    = e_inc[EW-1:0];
                state_next = ST_K_B;
            end

            ST_K_B: begin
                a_next    = cr_q;
                same_face = (e_inc < count_reg) && (fb_q == fa_q);
                if (same_face) begin
                    cr_addr = e_inc[EW-1:0];
                end else begin
                    cr_addr    = start_reg[EW-1:0];
                    start_next = e_inc;
                end
                state_next = ST_K_C;
            end

            ST_K_C: begin
                kw_en   = 1'b1;
                kw_addr = i_reg[EW-1:0];
                kw_data = cmp.gt ? {b_v, a_reg} : {a_reg, b_v};
                sw_en   = 1'b1;
                sw_addr = i_reg[EW-1:0];
                sw_data = i_reg[EW-1:0];
                tw_en   = 1'b1;
                tw_addr = i_reg[EW-1:0];
                tw_data = '0;
                if (e_inc >= count_reg) begin
                    i_next     = CW'(1);
                    state_next = ST_S_X0;
                end else begin
                    i_next     = e_inc;
                    state_next = ST_K_A;
                end
            end

            // stable insertion sort of edge numbers by key
            ST_S_X0: begin
                if (i_reg >= count_reg) begin
                    i_next     = '0;
                    state_next = ST_L0;
                end else begin
                    sa_addr    = i_reg[EW-1:0];
                    state_next = ST_S_X1;
                end
            end

            ST_S_X1: begin
                x_next     = sa_q;
                ka_addr    = sa_q;
                state_next = ST_S_X2;
            end

            ST_S_X2: begin
                kx_next    = ka_q;
                j_next     = i_reg;
                state_next = ST_S_J0;
            end

            ST_S_J0: begin
                if (j_reg == '0) begin
                    sw_en      = 1'b1;
                    sw_addr    = '0;
                    sw_data    = x_reg;
                    i_next     = e_inc;
                    state_next = ST_S_X0;
                end else begin
                    sa_addr    = EW'(j_reg - 1'b1);
                    state_next = ST_S_J1;
                end
            end

            ST_S_J1: begin
                y_next     = sa_q;
                ka_addr    = sa_q;
                state_next = ST_S_J2;
            end

            ST_S_J2: begin
                sw_en   = 1'b1;
                sw_addr = j_reg[EW-1:0];
                if (cmp.gt) begin
                    sw_data    = y_reg;
                    j_next     = j_reg - 1'b1;
                    state_next = ST_S_J0;
                end else begin
                    sw_data    = x_reg;
                    i_next     = e_inc;
                    state_next = ST_S_X0;
                end
            end

            // link pass: equal sorted neighbours become twins, later links win
            ST_L0: begin
                if (e_inc >= count_reg) begin
                    built_next = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    sa_addr    = i_reg[EW-1:0];
                    sb_addr    = e_inc[EW-1:0];
                    state_next = ST_L1;
                end
            end

            ST_L1: begin
                p_next     = sa_q;
                q_next     = sb_q;
                ka_addr    = sa_q;
                kb_addr    = sb_q;
                fa_addr    = sa_q;
                fb_addr    = sb_q;
                state_next = ST_L2;
            end

            ST_L2: begin
                if (cmp.eq) begin
                    tw_en      = 1'b1;
                    tw_addr    = p_reg;
                    tw_data    = {1'b1, q_reg, fb_q};
                    fp_next    = fa_q;
                    state_next = ST_L3;
                end else begin
                    i_next     = e_inc;
                    state_next = ST_L0;
                end
            end

            ST_L3: begin
                tw_en      = 1'b1;
                tw_addr    = q_reg;
                tw_data    = {1'b1, p_reg, fp_reg};
                i_next     = e_inc;
                state_next = ST_L0;
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
